@@ rtl/lppt_pkg.sv @@
package lppt_pkg;

  // pose layout: nine rotation words row-major, then translation x, y, z
  localparam int unsigned WordW          = 32;
  localparam int unsigned WordsPerPose   = 12;
  localparam int unsigned TransBase      = 9;
  localparam int unsigned DefaultColumns = 2048;
  localparam int unsigned ColumnW        = 11;
  localparam int unsigned FracShift      = 30;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } op_e;

  typedef logic [WordsPerPose*WordW-1:0] pose_row_t;

  // product of a q2.30 rotation word and a q16.16 coordinate
  typedef logic signed [2*WordW-1:0] prod_t;

  // partial sums and the full q.46 sum
  typedef logic signed [2*WordW:0]   psum_t;
  typedef logic signed [2*WordW+1:0] fsum_t;

  // saturate a q.46 sum, already offset by one half, to a q16.16 word
  function automatic logic signed [WordW-1:0] round_sat(input fsum_t s);
    logic signed [2*WordW+1-FracShift:0] hi;
    hi = s[2*WordW+1:FracShift];
    if (hi[2*WordW+1-FracShift:WordW-1] == '0 || hi[2*WordW+1-FracShift:WordW-1] == '1) begin
      return hi[WordW-1:0];
    end else if (hi[2*WordW+1-FracShift]) begin
      return {1'b1, {(WordW-1){1'b0}}};
    end else begin
      return {1'b0, {(WordW-1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/lidar_point_pose_transform_unit.sv @@
// channel   | direction | transaction marker   | payload
// ----------+-----------+----------------------+------------------------------------------
// command   | in        | start_i && !busy_o   | operation, column, word_index, word_value,
//           |           |                      | point_x, point_y, point_z
// result    | out       | done_o (one cycle)   | origin_x/y/z, moved_x/y/z
//
// one command is taken every cycle; busy_o stays low
// a point command gives its result strobe after these registered steps, in order:
// pose row read, nine multiplies, two partial sums, final add with rounding/saturation
// a load command writes its word at the accepting edge and gives no result
// reset clears only the pipeline valid bits and out-of-range flags; the pose memory is undefined until loaded
// the result side cannot stall, so nothing upstream ever waits
module lidar_point_pose_transform_unit import lppt_pkg::*; #(
  parameter int unsigned Columns = DefaultColumns
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    operation_i,
  input  logic [ColumnW-1:0]      column_i,
  input  logic [3:0]              word_index_i,
  input  logic signed [WordW-1:0] word_value_i,
  input  logic signed [WordW-1:0] point_x_i,
  input  logic signed [WordW-1:0] point_y_i,
  input  logic signed [WordW-1:0] point_z_i,
  output logic                    done_o,
  output logic signed [WordW-1:0] origin_x_o,
  output logic signed [WordW-1:0] origin_y_o,
  output logic signed [WordW-1:0] origin_z_o,
  output logic signed [WordW-1:0] moved_x_o,
  output logic signed [WordW-1:0] moved_y_o,
  output logic signed [WordW-1:0] moved_z_o
);

  localparam int unsigned AddrW = (Columns > 1) ? $clog2(Columns) : 1;

  // half an lsb of the q16.16 result, in q.46
  localparam psum_t RoundHalf = psum_t'(1) <<< (FracShift - 1);

  // one row per column holds the whole pose, loads write one word of it
  pose_row_t pose_mem [Columns];

  logic              accept;
  logic              is_point;
  logic [31:0]       col_ext;
  logic              in_range;
  logic [AddrW-1:0]  addr;
  logic              wr_en;
  logic              rd_en;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_point = (op_e'(operation_i) == OP_POINT);
  assign col_ext  = 32'(column_i);
  assign in_range = (col_ext < Columns);
  assign addr     = col_ext[AddrW-1:0];
  assign wr_en    = accept && !is_point && in_range && (word_index_i < 4'(WordsPerPose));
  assign rd_en    = accept && is_point && in_range;

  // stage valid bits and out-of-range flags
  logic       s1_vld_q, s2_vld_q, s3_vld_q, done_q;
  logic       s1_oob_q, s2_oob_q, s3_oob_q;

  // stage payload
  pose_row_t               row_q;
  logic signed [WordW-1:0] pt_q   [3];
  prod_t                   prod_q [3][3];
  logic signed [WordW-1:0] t2_q   [3];
  psum_t                   sa_q   [3];
  psum_t                   sb_q   [3];
  logic signed [WordW-1:0] t3_q   [3];
  logic signed [WordW-1:0] org_q  [3];
  logic signed [WordW-1:0] mov_q  [3];

  // memory write and row read at the accepting edge, so a point right after a load sees the new word
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int k = 0; k < WordsPerPose; k++) begin
        if (word_index_i == 4'(k)) begin
          pose_mem[addr][k*WordW +: WordW] <= word_value_i;
        end
      end
    end
    if (rd_en) begin
      row_q <= pose_mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      done_q   <= 1'b0;
      s1_oob_q <= 1'b0;
      s2_oob_q <= 1'b0;
      s3_oob_q <= 1'b0;
    end else begin
      s1_vld_q <= accept && is_point;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      done_q   <= s3_vld_q;
      s1_oob_q <= !in_range;
      s2_oob_q <= s1_oob_q;
      s3_oob_q <= s2_oob_q;
    end
  end

  // point coordinates ride along with the memory read
  always_ff @(posedge clk_i) begin
    if (accept && is_point) begin
      pt_q[0] <= point_x_i;
      pt_q[1] <= point_y_i;
      pt_q[2] <= point_z_i;
    end
  end

  // stage 2: nine q2.30 x q16.16 products, one multiplier each
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= prod_t'($signed(row_q[(i*3+j)*WordW +: WordW])) *
                          prod_t'(pt_q[j]);
        end
        t2_q[i] <= $signed(row_q[(TransBase+i)*WordW +: WordW]);
      end
    end
  end

  // stage 3: two partial sums per row, translation and rounding half folded in
  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      for (int i = 0; i < 3; i++) begin
        sa_q[i] <= psum_t'(prod_q[i][0]) + psum_t'(prod_q[i][1]);
        sb_q[i] <= psum_t'(prod_q[i][2]) + (psum_t'(t2_q[i]) <<< FracShift) + RoundHalf;
        t3_q[i] <= t2_q[i];
      end
    end
  end

  // stage 4: final add, floor shift and saturation; out-of-range columns give zeros
  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      for (int i = 0; i < 3; i++) begin
        if (s3_oob_q) begin
          org_q[i] <= '0;
          mov_q[i] <= '0;
        end else begin
          org_q[i] <= t3_q[i];
          mov_q[i] <= round_sat(fsum_t'(sa_q[i]) + fsum_t'(sb_q[i]));
        end
      end
    end
  end

  assign done_o     = done_q;
  assign origin_x_o = org_q[0];
  assign origin_y_o = org_q[1];
  assign origin_z_o = org_q[2];
  assign moved_x_o  = mov_q[0];
  assign moved_y_o  = mov_q[1];
  assign moved_z_o  = mov_q[2];

endmodule

@@ rtl/lppt_checker.sv @@
module lppt_checker import lppt_pkg::*; #(
  parameter int unsigned Columns = DefaultColumns
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic                    operation_i,
  input logic [ColumnW-1:0]      column_i,
  input logic                    done_o,
  input logic signed [WordW-1:0] origin_x_o,
  input logic signed [WordW-1:0] origin_y_o,
  input logic signed [WordW-1:0] origin_z_o,
  input logic signed [WordW-1:0] moved_x_o,
  input logic signed [WordW-1:0] moved_y_o,
  input logic signed [WordW-1:0] moved_z_o
);

  logic pt_acc;
  logic oob_acc;

  assign pt_acc  = start_i && !busy_o && (op_e'(operation_i) == OP_POINT);
  assign oob_acc = pt_acc && (32'(column_i) >= Columns);

  // every point transaction gets its result
  a_point_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_acc |-> ##4 done_o)
    else $error("point transaction without result");

  // no result without an earlier point transaction
  a_result_has_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(pt_acc, 4))
    else $error("result without point transaction");

  // a column outside the table gives an all-zero result
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oob_acc |-> ##4 (origin_x_o == 0 && origin_y_o == 0 && origin_z_o == 0 &&
                     moved_x_o == 0 && moved_y_o == 0 && moved_z_o == 0))
    else $error("out-of-range column gave a nonzero result");

endmodule

bind lidar_point_pose_transform_unit lppt_checker #(.Columns(Columns)) u_lppt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .operation_i (operation_i),
  .column_i    (column_i),
  .done_o      (done_o),
  .origin_x_o  (origin_x_o),
  .origin_y_o  (origin_y_o),
  .origin_z_o  (origin_z_o),
  .moved_x_o   (moved_x_o),
  .moved_y_o   (moved_y_o),
  .moved_z_o   (moved_z_o)
);
